### rtl/core/bscc_pkg.sv
package bscc_pkg;

  // Event codes carried on the op field of an input beat.
  typedef enum logic [1:0] {
    OP_BUTTON     = 2'd0,
    OP_CONNECT    = 2'd1,
    OP_DISCONNECT = 2'd2,
    OP_TICK       = 2'd3
  } op_t;

  // Button usage codes from the remote.
  localparam logic [15:0] USAGE_RELEASE = 16'h0000;
  localparam logic [15:0] USAGE_FULLF   = 16'h0001;
  localparam logic [15:0] USAGE_FULLB   = 16'h0002;
  localparam logic [15:0] USAGE_UP      = 16'h0004;
  localparam logic [15:0] USAGE_DOWN    = 16'h0008;
  localparam logic [15:0] USAGE_STOP    = 16'h0010;

  // Which long-press button is being held.
  typedef enum logic [1:0] {
    LONG_NONE = 2'd0,
    LONG_FWD  = 2'd1,
    LONG_BWD  = 2'd2
  } long_btn_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MAX_LEVEL       = 3'd0;
  localparam logic [2:0] CFG_DUTY_PER_LEVEL  = 3'd1;
  localparam logic [2:0] CFG_RELEASE_TIMEOUT = 3'd2;
  localparam logic [2:0] CFG_STOP_TIMEOUT    = 3'd3;
  localparam logic [2:0] CFG_FORWARD_LEVEL   = 3'd4;

  // Configuration reset values.
  localparam logic [3:0]  MAX_LEVEL_RST       = 4'd5;
  localparam logic [7:0]  DUTY_PER_LEVEL_RST  = 8'd51;
  localparam logic [15:0] RELEASE_TIMEOUT_RST = 16'd200;
  localparam logic [15:0] STOP_TIMEOUT_RST    = 16'd10000;
  localparam logic        FORWARD_LEVEL_RST   = 1'b1;

  localparam logic [15:0] MS_COUNT_MAX = 16'hFFFF;
  localparam logic [7:0]  DUTY_MAX     = 8'hFF;

  // Controller state, updated once per beat.
  typedef struct packed {
    logic signed [4:0] cmd_level;
    logic              enabled;
    logic              long_active;
    logic              long_detected;
    long_btn_t         long_button;
    logic [15:0]       since_long_ms;
    logic              connected;
    logic              disc_armed;
    logic [15:0]       disc_ms;
  } ctrl_state_t;

endpackage

### rtl/core/button_speed_command_controller_top.sv
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall   in_op[1:0], in_usage[15:0]
// out_      output     out_valid/out_stall out_duty[7:0], out_direction, out_motor_on,
//                                          out_level[4:0] signed, out_link_up
// cfg_      input      cfg_we              cfg_index[2:0], cfg_data[15:0]
//
// Every input beat yields exactly one result beat, via the input and result registers.
// A new beat is accepted every cycle while in_stall is low; the rate is set by the
// single state update between the input register and the result register.
// Reset (rst_n low, synchronous) clears both stages, restores the register defaults
// and arms the disconnect timer. While out_stall holds a full result register, the
// input register holds too, and in_stall rises once it is occupied.
module button_speed_command_controller_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [15:0]        in_usage,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_duty,
  output logic               out_direction,
  output logic               out_motor_on,
  output logic signed [4:0]  out_level,
  output logic               out_link_up,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // Configuration registers.
  logic [3:0]  max_level_r;
  logic [7:0]  duty_per_level_r;
  logic [15:0] release_timeout_r;
  logic [15:0] stop_timeout_r;
  logic        forward_level_r;

  // Input stage.
  logic               in_v_r;
  bscc_pkg::op_t      op_r;
  logic [15:0]        usage_r;

  // Controller state.
  bscc_pkg::ctrl_state_t st_r, st_nxt;

  // Result stage.
  logic               out_v_r;
  logic [7:0]         duty_r, duty_nxt;
  logic               dir_r, dir_nxt;
  logic               motor_on_r;
  logic signed [4:0]  level_r;
  logic               link_r;

  logic advance;
  logic signed [4:0] lim;
  logic [3:0]  mag;
  logic [11:0] prod;

  // The input stage moves on when the result slot is empty or being taken.
  assign advance  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && out_v_r && out_stall;
  assign lim      = $signed({1'b0, max_level_r});

  // Next state for the beat held in the input register. The blocks below follow
  // the event order exactly: counters first, then release, then the stop timer.
  always_comb begin
    st_nxt = st_r;
    case (op_r)
      bscc_pkg::OP_BUTTON: begin
        case (usage_r)
          bscc_pkg::USAGE_RELEASE: begin
            if (st_r.long_detected && (st_r.since_long_ms > release_timeout_r)) begin
              if (st_r.long_active) begin
                st_nxt.cmd_level   = '0;
                st_nxt.enabled     = 1'b0;
                st_nxt.long_active = 1'b0;
              end
              st_nxt.long_button   = bscc_pkg::LONG_NONE;
              st_nxt.long_detected = 1'b0;
              st_nxt.since_long_ms = '0;
            end
          end
          bscc_pkg::USAGE_UP: begin
            if (st_r.cmd_level < lim) begin
              st_nxt.cmd_level = st_r.cmd_level + 5'sd1;
              st_nxt.enabled   = (st_nxt.cmd_level != 5'sd0);
            end
          end
          bscc_pkg::USAGE_DOWN: begin
            if (st_r.cmd_level > -lim) begin
              st_nxt.cmd_level = st_r.cmd_level - 5'sd1;
              st_nxt.enabled   = (st_nxt.cmd_level != 5'sd0);
            end
          end
          bscc_pkg::USAGE_STOP: begin
            st_nxt.cmd_level   = '0;
            st_nxt.enabled     = 1'b0;
            st_nxt.long_active = 1'b0;
          end
          bscc_pkg::USAGE_FULLF, bscc_pkg::USAGE_FULLB: begin
            if (!st_r.long_detected ||
                (st_r.long_button != ((usage_r == bscc_pkg::USAGE_FULLF) ?
                                      bscc_pkg::LONG_FWD : bscc_pkg::LONG_BWD))) begin
              st_nxt.long_button   = (usage_r == bscc_pkg::USAGE_FULLF) ?
                                     bscc_pkg::LONG_FWD : bscc_pkg::LONG_BWD;
              st_nxt.long_detected = 1'b1;
              if (!st_r.long_active) begin
                st_nxt.long_active = 1'b1;
                st_nxt.cmd_level   = (usage_r == bscc_pkg::USAGE_FULLF) ? lim : -lim;
                st_nxt.enabled     = 1'b1;
              end
            end
            st_nxt.since_long_ms = '0;
          end
          default: begin
          end
        endcase
      end
      bscc_pkg::OP_CONNECT: begin
        st_nxt.connected  = 1'b1;
        st_nxt.disc_armed = 1'b0;
        st_nxt.disc_ms    = '0;
      end
      bscc_pkg::OP_DISCONNECT: begin
        st_nxt.connected   = 1'b0;
        st_nxt.disc_armed  = 1'b1;
        st_nxt.disc_ms     = '0;
        st_nxt.cmd_level   = '0;
        st_nxt.enabled     = 1'b0;
        st_nxt.long_active = 1'b0;
      end
      bscc_pkg::OP_TICK: begin
        if (st_r.long_detected && (st_r.since_long_ms != bscc_pkg::MS_COUNT_MAX)) begin
          st_nxt.since_long_ms = st_r.since_long_ms + 16'd1;
        end
        if (st_r.disc_armed && !st_r.connected &&
            (st_r.disc_ms != bscc_pkg::MS_COUNT_MAX)) begin
          st_nxt.disc_ms = st_r.disc_ms + 16'd1;
        end
        if (st_r.long_detected && (st_nxt.since_long_ms > release_timeout_r)) begin
          if (st_r.long_active) begin
            st_nxt.cmd_level   = '0;
            st_nxt.enabled     = 1'b0;
            st_nxt.long_active = 1'b0;
          end
          st_nxt.long_button   = bscc_pkg::LONG_NONE;
          st_nxt.long_detected = 1'b0;
          st_nxt.since_long_ms = '0;
        end
        if (!st_r.connected && st_r.disc_armed && (st_nxt.disc_ms >= stop_timeout_r)) begin
          // The stop only fires when something is running; a held long
          // press with the motor already stopped keeps its active flag.
          if (st_nxt.enabled || (st_nxt.cmd_level != 5'sd0)) begin
            st_nxt.cmd_level   = '0;
            st_nxt.enabled     = 1'b0;
            st_nxt.long_active = 1'b0;
          end
          st_nxt.disc_armed = 1'b0;
          st_nxt.disc_ms    = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Duty and direction from the updated state.
  assign mag  = st_nxt.cmd_level[4] ? 4'(-st_nxt.cmd_level) : st_nxt.cmd_level[3:0];
  assign prod = mag * duty_per_level_r;

  always_comb begin
    duty_nxt = '0;
    dir_nxt  = forward_level_r;
    if (st_nxt.enabled && (st_nxt.cmd_level != 5'sd0)) begin
      duty_nxt = (prod > 12'(bscc_pkg::DUTY_MAX)) ? bscc_pkg::DUTY_MAX : prod[7:0];
      if (st_nxt.cmd_level[4]) begin
        dir_nxt = ~forward_level_r;
      end
    end
  end

  // Control, state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r               <= 1'b0;
      out_v_r              <= 1'b0;
      max_level_r          <= bscc_pkg::MAX_LEVEL_RST;
      duty_per_level_r     <= bscc_pkg::DUTY_PER_LEVEL_RST;
      release_timeout_r    <= bscc_pkg::RELEASE_TIMEOUT_RST;
      stop_timeout_r       <= bscc_pkg::STOP_TIMEOUT_RST;
      forward_level_r      <= bscc_pkg::FORWARD_LEVEL_RST;
      st_r.cmd_level       <= '0;
      st_r.enabled         <= 1'b0;
      st_r.long_active     <= 1'b0;
      st_r.long_detected   <= 1'b0;
      st_r.long_button     <= bscc_pkg::LONG_NONE;
      st_r.since_long_ms   <= '0;
      st_r.connected       <= 1'b0;
      st_r.disc_armed      <= 1'b1;
      st_r.disc_ms         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bscc_pkg::CFG_MAX_LEVEL:       max_level_r       <= cfg_data[3:0];
          bscc_pkg::CFG_DUTY_PER_LEVEL:  duty_per_level_r  <= cfg_data[7:0];
          bscc_pkg::CFG_RELEASE_TIMEOUT: release_timeout_r <= cfg_data;
          bscc_pkg::CFG_STOP_TIMEOUT:    stop_timeout_r    <= cfg_data;
          bscc_pkg::CFG_FORWARD_LEVEL:   forward_level_r   <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (!in_stall) begin
        in_v_r <= in_valid;
      end
      if (advance) begin
        st_r    <= st_nxt;
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      op_r    <= bscc_pkg::op_t'(in_op);
      usage_r <= in_usage;
    end
    if (advance) begin
      duty_r     <= duty_nxt;
      dir_r      <= dir_nxt;
      motor_on_r <= st_nxt.enabled;
      level_r    <= st_nxt.cmd_level;
      link_r     <= st_nxt.connected;
    end
  end

  assign out_valid     = out_v_r;
  assign out_duty      = duty_r;
  assign out_direction = dir_r;
  assign out_motor_on  = motor_on_r;
  assign out_level     = level_r;
  assign out_link_up   = link_r;

endmodule
